@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the HSV balance block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HSVB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define HSVB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/hsvb_pkg.sv @@
// Package for the dual camera HSV balance loop: widths, codes and the
// command, status and configuration structs. Depends on nothing.
package hsvb_pkg;

    localparam int AVG_W     = 9;
    localparam int DELTA_W   = 10;
    localparam int LVL_W     = 7;
    localparam int CNT_W     = 7;
    localparam int THR_W     = 8;
    localparam int DIV_STEPS = 9;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [LVL_W-1:0] LEVEL_RESET = 7'd50;

    // Channel codes.
    localparam logic [1:0] CH_HUE = 2'd0;
    localparam logic [1:0] CH_SAT = 2'd1;
    localparam logic [1:0] CH_VAL = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_AUTO   = 2'd0;
    localparam logic [1:0] REG_THR    = 2'd1;
    localparam logic [1:0] REG_RELOAD = 2'd2;

    typedef struct packed {
        logic             auto_en;
        logic [THR_W-1:0] thr;
        logic [CNT_W-1:0] reload;
    } t_hsvb_cfg;

    typedef struct packed {
        logic       load_in;
        logic       delta;
        logic       dec;
        logic       div_start;
        logic       step;
        logic       out_load;
        logic [1:0] ch;
    } t_hsvb_cmd;

    typedef struct packed {
        logic cnt_gt1;
        logic div_done;
    } t_hsvb_sts;

endpackage

@@ src/hsvb_div.sv @@
// Restoring divider for the decay scaling: one quotient bit per cycle.
// Depends on hsvb_pkg.
module hsvb_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hsvb_pkg::AVG_W-1:0]     i_dividend,
    input  logic [hsvb_pkg::CNT_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [hsvb_pkg::AVG_W-1:0]     o_quotient
);
    import hsvb_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dsr;
    logic [AVG_W-1:0]     r_quo;
    logic [CNT_W:0]       shifted;
    logic                 fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        shifted = {r_rem, r_quo[AVG_W-1]};
        fits    = shifted >= {1'b0, r_dsr};
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? CNT_W'(shifted - {1'b0, r_dsr}) : shifted[CNT_W-1:0];
            r_quo <= {r_quo[AVG_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/hsvb_dp.sv @@
// Datapath of the HSV balance loop: averages, deltas, decay counters,
// camera levels and the result registers. Depends on hsvb_pkg, hsvb_div.
module hsvb_dp #(
    parameter int LEVEL_MAX = 100
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hsvb_pkg::t_hsvb_cmd                i_cmd,
    input  hsvb_pkg::t_hsvb_cfg                i_cfg,
    output hsvb_pkg::t_hsvb_sts                o_sts,
    input  logic                               i_source_is_master,
    input  logic [8:0]                         i_hue_average,
    input  logic [7:0]                         i_sat_average,
    input  logic [7:0]                         i_val_average,
    output logic signed [9:0]                  o_hue_delta,
    output logic signed [8:0]                  o_sat_delta,
    output logic signed [8:0]                  o_val_delta,
    output logic [6:0]                         o_slave_hue,
    output logic [6:0]                         o_slave_sat,
    output logic [6:0]                         o_slave_bright,
    output logic [6:0]                         o_master_hue,
    output logic [6:0]                         o_master_sat,
    output logic [4:0]                         o_changed_mask
);
    import hsvb_pkg::*;

    localparam logic signed [LVL_W+1:0] LMAX_S = (LVL_W+2)'(LEVEL_MAX);

    logic        [AVG_W-1:0]   r_mavg [3];
    logic        [AVG_W-1:0]   r_savg [3];
    logic        [CNT_W-1:0]   r_cnt  [3];
    logic        [LVL_W-1:0]   r_slv  [3];
    logic        [LVL_W-1:0]   r_mst  [2];
    logic signed [DELTA_W-1:0] r_raw  [3];
    logic        [AVG_W-1:0]   r_mag;
    logic                      r_neg;
    logic        [4:0]         r_mask;

    logic signed [DELTA_W-1:0] cur_raw;
    logic        [AVG_W-1:0]   cur_abs;
    logic        [CNT_W-1:0]   cur_cnt;
    logic                      div_done;
    logic        [AVG_W-1:0]   div_quo;
    logic        [LVL_W-1:0]   s_old;
    logic        [LVL_W-1:0]   m_old;
    logic signed [LVL_W+1:0]   s_raw;
    logic signed [LVL_W+1:0]   m_raw;
    logic        [LVL_W-1:0]   s_new;
    logic        [LVL_W-1:0]   m_new;
    logic                      at_limit;
    logic                      step_en;
    logic                      s_chg;
    logic                      m_chg;

    // Clamp a stepped level into 0..LEVEL_MAX.
    function automatic logic [LVL_W-1:0] clamp_lvl(input logic signed [LVL_W+1:0] v);
        logic [LVL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > LMAX_S) begin
            res = LMAX_S[LVL_W-1:0];
        end else begin
            res = v[LVL_W-1:0];
        end
        return res;
    endfunction

    // Values of the channel being worked on.
    always_comb begin
        cur_raw = r_raw[i_cmd.ch];
        cur_abs = cur_raw[DELTA_W-1] ? AVG_W'(-cur_raw) : cur_raw[AVG_W-1:0];
        cur_cnt = r_cnt[i_cmd.ch];
        o_sts.cnt_gt1  = cur_cnt > CNT_W'(1);
        o_sts.div_done = div_done;
    end

    hsvb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (cur_abs),
        .i_divisor  (cur_cnt - CNT_W'(1)),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Level step: the slave moves toward the master, or the master moves
    // the other way when the slave hue or saturation has hit a limit.
    always_comb begin
        s_old    = r_slv[i_cmd.ch];
        m_old    = r_mst[i_cmd.ch[0]];
        s_raw    = r_neg ? $signed({2'b00, s_old}) - 9'sd1 : $signed({2'b00, s_old}) + 9'sd1;
        m_raw    = r_neg ? $signed({2'b00, m_old}) + 9'sd1 : $signed({2'b00, m_old}) - 9'sd1;
        s_new    = clamp_lvl(s_raw);
        m_new    = clamp_lvl(m_raw);
        at_limit = (i_cmd.ch != CH_VAL) && ((s_raw > LMAX_S) || (s_raw < 0));
        step_en  = i_cfg.auto_en && (r_mag > {1'b0, i_cfg.thr});
        s_chg    = !at_limit && (s_new != s_old);
        m_chg    = at_limit && (m_new != m_old);
    end

    // Stored averages and deltas.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_mavg[i] <= '0;
                r_savg[i] <= '0;
            end
        end else if (i_cmd.load_in) begin
            if (i_source_is_master) begin
                r_mavg[0] <= i_hue_average;
                r_mavg[1] <= {1'b0, i_sat_average};
                r_mavg[2] <= {1'b0, i_val_average};
            end else begin
                r_savg[0] <= i_hue_average;
                r_savg[1] <= {1'b0, i_sat_average};
                r_savg[2] <= {1'b0, i_val_average};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.delta) begin
            for (int i = 0; i < 3; i++) begin
                r_raw[i] <= $signed({1'b0, r_mavg[i]}) - $signed({1'b0, r_savg[i]});
            end
        end
    end

    // Scaled magnitude: the plain delta, replaced by the quotient when the
    // decay counter is still running.
    always_ff @(posedge i_clk) begin
        if (i_cmd.dec) begin
            r_mag <= cur_abs;
            r_neg <= cur_raw[DELTA_W-1];
        end else if (div_done) begin
            r_mag <= div_quo;
        end
    end

    // Decay counters, levels and the change mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_cnt[i] <= '0;
                r_slv[i] <= LEVEL_RESET;
            end
            r_mst[0] <= LEVEL_RESET;
            r_mst[1] <= LEVEL_RESET;
            r_mask   <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_mask <= '0;
            end
            if (i_cmd.dec && (cur_cnt != '0)) begin
                r_cnt[i_cmd.ch] <= cur_cnt - CNT_W'(1);
            end
            if (i_cmd.step && step_en) begin
                r_slv[i_cmd.ch] <= s_new;
                if (at_limit) begin
                    r_mst[i_cmd.ch[0]] <= m_new;
                end
                if (s_chg || m_chg) begin
                    r_cnt[i_cmd.ch] <= i_cfg.reload;
                end
                if (s_chg) begin
                    r_mask[{1'b0, i_cmd.ch}] <= 1'b1;
                end
                if (m_chg) begin
                    r_mask[3'd3 + {2'b00, i_cmd.ch[0]}] <= 1'b1;
                end
            end
        end
    end

    // Result word registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hue_delta    <= r_raw[0];
            o_sat_delta    <= r_raw[1][8:0];
            o_val_delta    <= r_raw[2][8:0];
            o_slave_hue    <= r_slv[0];
            o_slave_sat    <= r_slv[1];
            o_slave_bright <= r_slv[2];
            o_master_hue   <= r_mst[0];
            o_master_sat   <= r_mst[1];
            o_changed_mask <= r_mask;
        end
    end

endmodule

@@ src/hsvb_ctrl.sv @@
// Controller of the HSV balance loop: sequences one word through delta,
// per-channel decay, divide and step, then hands it out. Depends on hsvb_pkg.
module hsvb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  hsvb_pkg::t_hsvb_sts i_sts,
    output hsvb_pkg::t_hsvb_cmd o_cmd
);
    import hsvb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_ch;
    logic [1:0] n_ch;
    logic       r_valid;
    logic       n_valid;
    logic       accept;
    logic       out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_valid || !i_stall;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_ch            = r_ch;
        o_cmd           = '0;
        o_cmd.ch        = r_ch;
        o_cmd.load_in   = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DELTA;
                    n_ch    = CH_HUE;
                end
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                if (i_sts.cnt_gt1) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (r_ch == CH_VAL) begin
                    n_state = S_DONE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = S_DEC;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the word is taken.
    always_comb begin
        n_valid = r_valid;
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= CH_HUE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

@@ src/dual_camera_hsv_balance_loop_top.sv @@
// Flow: an accepted word goes through a delta state, then per channel a decay
// state, the 9-step divider when its decay counter needs it, and a step state,
// and is then loaded out. One word is in work at a time: no new word is taken
// until the last one is loaded, and all channels use the shared divider. The result register lets a word wait.
// Reset (synchronous, active low): averages and decay counters to zero, all
// levels to fifty, auto off, threshold 15, decay reload 1.
module dual_camera_hsv_balance_loop_top #(
    parameter int LEVEL_MAX = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_source_is_master,
    input  logic [8:0]         i_hue_average,
    input  logic [7:0]         i_sat_average,
    input  logic [7:0]         i_val_average,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [9:0]  o_hue_delta,
    output logic signed [8:0]  o_sat_delta,
    output logic signed [8:0]  o_val_delta,
    output logic [6:0]         o_slave_hue,
    output logic [6:0]         o_slave_sat,
    output logic [6:0]         o_slave_bright,
    output logic [6:0]         o_master_hue,
    output logic [6:0]         o_master_sat,
    output logic [4:0]         o_changed_mask
);
    import hsvb_pkg::*;

    logic             r_auto;
    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_reload;
    logic [1:0]       reg_idx;
    logic             wr_en;
    t_hsvb_cfg        cfg;
    t_hsvb_cmd        cmd;
    t_hsvb_sts        sts;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto   <= 1'b0;
            r_thr    <= 8'd15;
            r_reload <= 7'd1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_AUTO:   r_auto   <= pwdata[0];
                REG_THR:    r_thr    <= pwdata[THR_W-1:0];
                REG_RELOAD: r_reload <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_idx)
            REG_AUTO:   prdata = {31'd0, r_auto};
            REG_THR:    prdata = {24'd0, r_thr};
            REG_RELOAD: prdata = {25'd0, r_reload};
            default:    prdata = '0;
        endcase
    end

    assign cfg.auto_en = r_auto;
    assign cfg.thr     = r_thr;
    assign cfg.reload  = r_reload;

    hsvb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hsvb_dp #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_cfg              (cfg),
        .o_sts              (sts),
        .i_source_is_master (i_source_is_master),
        .i_hue_average      (i_hue_average),
        .i_sat_average      (i_sat_average),
        .i_val_average      (i_val_average),
        .o_hue_delta        (o_hue_delta),
        .o_sat_delta        (o_sat_delta),
        .o_val_delta        (o_val_delta),
        .o_slave_hue        (o_slave_hue),
        .o_slave_sat        (o_slave_sat),
        .o_slave_bright     (o_slave_bright),
        .o_master_hue       (o_master_hue),
        .o_master_sat       (o_master_sat),
        .o_changed_mask     (o_changed_mask)
    );

endmodule

@@ src/hsvb_check.sv @@
// Port-level checker for the HSV balance loop and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hsvb_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [6:0]  o_slave_hue,
    input logic [4:0]  o_changed_mask
);

    // An accepted word keeps the input side closed on the next cycle.
    `HSVB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall, "input taken while a word is in work")

    // A stalled result word stays in place.
    `HSVB_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_slave_hue) && $stable(o_changed_mask)), "stalled result word changed")

    // Slave and master hue never move in the same word, nor do the two saturations.
    `HSVB_ASSERT(a_one_mover, i_clk, i_rst_n, o_valid |-> !((o_changed_mask[0] && o_changed_mask[3]) || (o_changed_mask[1] && o_changed_mask[4])), "slave and master stepped together")

    // Reset leaves no result word behind.
    `HSVB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind dual_camera_hsv_balance_loop_top hsvb_check u_hsvb_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_slave_hue    (o_slave_hue),
    .o_changed_mask (o_changed_mask)
);
